// ===== design/gdgc_pkg.sv =====
`default_nettype none
// ============================================================================
// gdgc_pkg: shared types and constants for the gamepad drive/gimbal core
// Holds the controller-to-datapath command struct, the register index codes
// and the configuration and field widths.
// ============================================================================
package gdgc_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_COOLDOWN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_STEP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LIMIT     = 3'd5;

    // Result widths
    localparam int SPEED_W = 16;
    localparam int ANGLE_W = 15;

    // Which product the shared gain multiplier forms this cycle
    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_FWD,
        STEP_SIDE,
        STEP_ROT
    } t_step;

    typedef struct packed {
        logic  load;    // capture the input item
        t_step step;    // multiplier operand and destination
        logic  commit;  // update state and load the result register
    } t_cmd;

endpackage
`default_nettype wire

// ===== design/gamepad_drive_and_gimbal_control_core.sv =====
`default_nettype none
// ============================================================================
// gamepad_drive_and_gimbal_control_core: gamepad frame to drive and gimbal
// Turns one polled gamepad frame into three drive speeds, a tracking-mode
// toggle and debounced pan/tilt gimbal angles.
// ============================================================================
// One item in, one item out. A frame is taken when mode reads 0x73 and the
// four stick axes are neither all 0x00 nor all 0xFF; any other frame returns
// a stop item (drive_enable low, speeds and flags zero, stored tracking and
// angles shown) and leaves all state untouched. After acceptance the shared
// 8x9 gain multiplier forms the forward, lateral and rotate products in the
// steps S_FWD, S_SIDE and S_ROT in turn, and the final step S_DIV divides
// the lateral term by ten (reciprocal multiply) and commits state and
// result. The next item is accepted in that commit step, so a new item is
// taken only as the last one commits. A result waits in an output
// register; while it is not taken, the core holds in its commit step and
// stops accepting. Write the configuration registers only while the core
// is idle. No clearing pass is needed after reset.
// ============================================================================
module gamepad_drive_and_gimbal_control_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [gdgc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [gdgc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input item channel
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [7:0]                         i_pad_mode,
    input  wire logic [7:0]                         i_left_horizontal,
    input  wire logic [7:0]                         i_left_vertical,
    input  wire logic [7:0]                         i_right_horizontal,
    input  wire logic [7:0]                         i_right_vertical,
    input  wire logic                               i_pad_up,
    input  wire logic                               i_pad_down,
    input  wire logic                               i_pad_right,
    input  wire logic                               i_pad_left,
    input  wire logic                               i_select_held,
    input  wire logic [3:0]                         i_servo_buttons,
    // result item channel
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic                                    o_drive_enable,
    output logic signed [gdgc_pkg::SPEED_W-1:0]     o_forward_speed,
    output logic signed [gdgc_pkg::SPEED_W-1:0]     o_lateral_speed,
    output logic signed [gdgc_pkg::SPEED_W-1:0]     o_rotate_speed,
    output logic                                    o_toggle_fired,
    output logic                                    o_tracking_active,
    output logic signed [gdgc_pkg::ANGLE_W-1:0]     o_pan_angle,
    output logic signed [gdgc_pkg::ANGLE_W-1:0]     o_tilt_angle,
    output logic                                    o_pan_moved,
    output logic                                    o_tilt_moved
);

    // command word from the sequencer: capture, multiply step, commit
    gdgc_pkg::t_cmd cmd;

    gdgc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    // all arithmetic, state and the result register live here
    gdgc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (cmd),
        .i_pad_mode         (i_pad_mode),
        .i_left_horizontal  (i_left_horizontal),
        .i_left_vertical    (i_left_vertical),
        .i_right_horizontal (i_right_horizontal),
        .i_right_vertical   (i_right_vertical),
        .i_pad_up           (i_pad_up),
        .i_pad_down         (i_pad_down),
        .i_pad_right        (i_pad_right),
        .i_pad_left         (i_pad_left),
        .i_select_held      (i_select_held),
        .i_servo_buttons    (i_servo_buttons),
        .o_drive_enable     (o_drive_enable),
        .o_forward_speed    (o_forward_speed),
        .o_lateral_speed    (o_lateral_speed),
        .o_rotate_speed     (o_rotate_speed),
        .o_toggle_fired     (o_toggle_fired),
        .o_tracking_active  (o_tracking_active),
        .o_pan_angle        (o_pan_angle),
        .o_tilt_angle       (o_tilt_angle),
        .o_pan_moved        (o_pan_moved),
        .o_tilt_moved       (o_tilt_moved)
    );

endmodule
`default_nettype wire

// ===== design/gdgc_ctrl.sv =====
`default_nettype none
// ============================================================================
// gdgc_ctrl: sequencing controller
// Walks each item through the forward, lateral and rotate multiply steps and
// the divide/commit step, and owns both handshakes.
// ============================================================================
module gdgc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  wire logic          i_ready,
    output gdgc_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FWD,
        S_SIDE,
        S_ROT,
        S_DIV
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;
    logic   in_fire;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) || ((r_state == S_DIV) && out_free);
    assign in_fire  = i_valid && o_ready;
    assign o_valid  = r_out_valid;

    always_comb begin
        o_cmd.load   = in_fire;
        o_cmd.commit = (r_state == S_DIV) && out_free;
        unique case (r_state)
            S_FWD:   o_cmd.step = gdgc_pkg::STEP_FWD;
            S_SIDE:  o_cmd.step = gdgc_pkg::STEP_SIDE;
            S_ROT:   o_cmd.step = gdgc_pkg::STEP_ROT;
            default: o_cmd.step = gdgc_pkg::STEP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) r_state <= S_FWD;
                end
                S_FWD:  r_state <= S_SIDE;
                S_SIDE: r_state <= S_ROT;
                S_ROT:  r_state <= S_DIV;
                S_DIV: begin
                    // hold here until the result register frees up
                    if (out_free) r_state <= in_fire ? S_FWD : S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase

            if ((r_state == S_DIV) && out_free) r_out_valid <= 1'b1;
            else if (i_ready)                   r_out_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== design/gdgc_dp.sv =====
`default_nettype none
// ============================================================================
// gdgc_dp: datapath
// Input capture, configuration registers, shared gain multiplier, divide by
// ten, tracking toggle, servo debounce and angle state, result register.
// ============================================================================
module gdgc_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [gdgc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [gdgc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire gdgc_pkg::t_cmd                     i_cmd,
    input  wire logic [7:0]                         i_pad_mode,
    input  wire logic [7:0]                         i_left_horizontal,
    input  wire logic [7:0]                         i_left_vertical,
    input  wire logic [7:0]                         i_right_horizontal,
    input  wire logic [7:0]                         i_right_vertical,
    input  wire logic                               i_pad_up,
    input  wire logic                               i_pad_down,
    input  wire logic                               i_pad_right,
    input  wire logic                               i_pad_left,
    input  wire logic                               i_select_held,
    input  wire logic [3:0]                         i_servo_buttons,
    output logic                                    o_drive_enable,
    output logic signed [gdgc_pkg::SPEED_W-1:0]     o_forward_speed,
    output logic signed [gdgc_pkg::SPEED_W-1:0]     o_lateral_speed,
    output logic signed [gdgc_pkg::SPEED_W-1:0]     o_rotate_speed,
    output logic                                    o_toggle_fired,
    output logic                                    o_tracking_active,
    output logic signed [gdgc_pkg::ANGLE_W-1:0]     o_pan_angle,
    output logic signed [gdgc_pkg::ANGLE_W-1:0]     o_tilt_angle,
    output logic                                    o_pan_moved,
    output logic                                    o_tilt_moved
);

    localparam logic [7:0]  MODE_ANALOG = 8'h73;
    localparam logic [19:0] RECIP10     = 20'd838861;  // ceil(2^23 / 10)

    function automatic logic signed [8:0] f_dead(input logic signed [8:0] v,
                                                 input logic [7:0] dz);
        logic signed [9:0] v10;
        logic signed [9:0] dz10;
        v10  = {v[8], v};
        dz10 = {2'b00, dz};
        if ((v10 > -dz10) && (v10 < dz10)) return 9'sd0;
        return v;
    endfunction

    // configuration
    logic [7:0]  r_gain, r_dz, r_cool;
    logic [3:0]  r_db_lim;
    logic [6:0]  r_step;
    logic [13:0] r_lim;

    // captured item
    logic [7:0]  r_mode, r_lh, r_lv, r_rh, r_rv;
    logic        r_up, r_down, r_right, r_left, r_sel;
    logic [3:0]  r_btn;

    // speed datapath
    logic signed [17:0] r_side_prod;
    logic [15:0]        r_fwd_spd, r_rot_spd;
    logic [18:0]        r_mag13;
    logic               r_side_neg;

    // persistent state
    logic               r_sel_before, r_tracking;
    logic [7:0]         r_cooldown;
    logic [3:0]         r_agree [4];
    logic [3:0]         r_level;
    logic signed [14:0] r_pan, r_tilt, r_pan_sent, r_tilt_sent;

    // result register
    logic        r_o_en, r_o_fired, r_o_track, r_o_pmv, r_o_tmv;
    logic [15:0] r_o_fwd, r_o_lat, r_o_rot;
    logic [14:0] r_o_pan, r_o_tilt;

    // ---------------- centring and multiplier ----------------
    logic signed [8:0]  fwd_v, side_v, rot_v, neg_side, neg_rot, mul_b;
    logic signed [17:0] prod;
    logic [17:0]        side_abs;
    logic [18:0]        side_m, mag13;
    logic [38:0]        recip;
    logic [15:0]        quot, lat;

    always_comb begin
        fwd_v  = f_dead(9'sd128 - $signed({1'b0, r_lv}), r_dz);
        side_v = f_dead($signed({1'b0, r_lh}) - 9'sd128, r_dz);
        rot_v  = f_dead($signed({1'b0, r_rh}) - 9'sd128, r_dz);
        // down wins over up, left over right
        if (r_up)    fwd_v  = 9'sd128;
        if (r_down)  fwd_v  = -9'sd127;
        if (r_right) side_v = 9'sd127;
        if (r_left)  side_v = -9'sd128;
        neg_side = -side_v;
        neg_rot  = -rot_v;
        unique case (i_cmd.step)
            gdgc_pkg::STEP_FWD:  mul_b = fwd_v;
            gdgc_pkg::STEP_SIDE: mul_b = neg_side;
            gdgc_pkg::STEP_ROT:  mul_b = neg_rot;
            default:             mul_b = 9'sd0;
        endcase
        prod = $signed({1'b0, r_gain}) * mul_b;

        side_abs = r_side_prod[17] ? 18'(-r_side_prod) : 18'(r_side_prod);
        side_m   = {4'b0000, side_abs[14:0]};
        mag13    = (side_m << 3) + (side_m << 2) + side_m;

        recip = 39'(r_mag13) * 39'(RECIP10);
        quot  = recip[38:23];
        lat   = r_side_neg ? 16'(-quot) : quot;
    end

    // ---------------- frame check, toggle and servo update ----------------
    logic               frame_ok, toggle;
    logic [7:0]         cd_dec, n_cooldown;
    logic               n_tracking;
    logic [3:0]         n_agree [4];
    logic [3:0]         n_level;
    logic signed [16:0] st17, lim17, pan_sum, tilt_sum;
    logic signed [14:0] pan_new, tilt_new;

    always_comb begin
        frame_ok = (r_mode == MODE_ANALOG)
                && !((r_lh == 8'h00) && (r_lv == 8'h00) && (r_rh == 8'h00) && (r_rv == 8'h00))
                && !((r_lh == 8'hFF) && (r_lv == 8'hFF) && (r_rh == 8'hFF) && (r_rv == 8'hFF));

        cd_dec     = (r_cooldown != 8'd0) ? r_cooldown - 8'd1 : 8'd0;
        toggle     = r_sel_before && !r_sel && (cd_dec == 8'd0);
        n_tracking = r_tracking ^ toggle;
        n_cooldown = toggle ? r_cool : cd_dec;

        for (int i = 0; i < 4; i++) begin
            n_agree[i] = r_agree[i];
            n_level[i] = r_level[i];
            if (r_btn[i] == r_level[i]) begin
                if (r_agree[i] < r_db_lim) n_agree[i] = r_agree[i] + 4'd1;
            end else if (r_agree[i] != 4'd0) begin
                n_agree[i] = r_agree[i] - 4'd1;
            end else begin
                n_level[i] = r_btn[i];
            end
        end

        st17  = {10'b0, r_step};
        lim17 = {3'b000, r_lim};
        pan_sum  = {{2{r_pan[14]}}, r_pan}
                 + (n_level[0] ? st17 : 17'sd0) - (n_level[1] ? st17 : 17'sd0);
        tilt_sum = {{2{r_tilt[14]}}, r_tilt}
                 + (n_level[2] ? st17 : 17'sd0) - (n_level[3] ? st17 : 17'sd0);

        if (pan_sum > lim17)       pan_new = lim17[14:0];
        else if (pan_sum < -lim17) pan_new = 15'(-lim17);
        else                       pan_new = pan_sum[14:0];
        if (tilt_sum > lim17)       tilt_new = lim17[14:0];
        else if (tilt_sum < -lim17) tilt_new = 15'(-lim17);
        else                        tilt_new = tilt_sum[14:0];
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= 8'd12;
            r_dz         <= 8'd6;
            r_cool       <= 8'd15;
            r_db_lim     <= 4'd3;
            r_step       <= 7'd12;
            r_lim        <= 14'd900;
            r_sel_before <= 1'b0;
            r_tracking   <= 1'b0;
            r_cooldown   <= 8'd0;
            r_level      <= 4'd0;
            r_pan        <= 15'sd0;
            r_tilt       <= 15'sd0;
            r_pan_sent   <= 15'sd0;
            r_tilt_sent  <= 15'sd0;
            for (int i = 0; i < 4; i++) r_agree[i] <= 4'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gdgc_pkg::CFG_SPEED_GAIN:      r_gain   <= i_cfg_data[7:0];
                    gdgc_pkg::CFG_DEAD_ZONE:       r_dz     <= i_cfg_data[7:0];
                    gdgc_pkg::CFG_TOGGLE_COOLDOWN: r_cool   <= i_cfg_data[7:0];
                    gdgc_pkg::CFG_DEBOUNCE_LIMIT:  r_db_lim <= i_cfg_data[3:0];
                    gdgc_pkg::CFG_SERVO_STEP:      r_step   <= i_cfg_data[6:0];
                    gdgc_pkg::CFG_ANGLE_LIMIT:     r_lim    <= i_cfg_data[13:0];
                    default: ;
                endcase
            end
            if (i_cmd.commit && frame_ok) begin
                r_sel_before <= r_sel;
                r_tracking   <= n_tracking;
                r_cooldown   <= n_cooldown;
                if (!n_tracking) begin
                    r_level     <= n_level;
                    r_pan       <= pan_new;
                    r_tilt      <= tilt_new;
                    r_pan_sent  <= pan_new;
                    r_tilt_sent <= tilt_new;
                    for (int i = 0; i < 4; i++) r_agree[i] <= n_agree[i];
                end
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_pad_mode;
            r_lh    <= i_left_horizontal;
            r_lv    <= i_left_vertical;
            r_rh    <= i_right_horizontal;
            r_rv    <= i_right_vertical;
            r_up    <= i_pad_up;
            r_down  <= i_pad_down;
            r_right <= i_pad_right;
            r_left  <= i_pad_left;
            r_sel   <= i_select_held;
            r_btn   <= i_servo_buttons;
        end

        unique case (i_cmd.step)
            gdgc_pkg::STEP_FWD:  r_fwd_spd   <= prod[15:0];
            gdgc_pkg::STEP_SIDE: r_side_prod <= prod;
            gdgc_pkg::STEP_ROT: begin
                r_rot_spd  <= {prod[13:0], 2'b00};
                r_mag13    <= mag13;
                r_side_neg <= r_side_prod[17];
            end
            default: ;
        endcase

        if (i_cmd.commit) begin
            if (frame_ok) begin
                r_o_en    <= 1'b1;
                r_o_fwd   <= r_fwd_spd;
                r_o_lat   <= lat;
                r_o_rot   <= r_rot_spd;
                r_o_fired <= toggle;
                r_o_track <= n_tracking;
                r_o_pan   <= n_tracking ? r_pan : pan_new;
                r_o_tilt  <= n_tracking ? r_tilt : tilt_new;
                r_o_pmv   <= !n_tracking && (pan_new != r_pan_sent);
                r_o_tmv   <= !n_tracking && (tilt_new != r_tilt_sent);
            end else begin
                r_o_en    <= 1'b0;
                r_o_fwd   <= 16'd0;
                r_o_lat   <= 16'd0;
                r_o_rot   <= 16'd0;
                r_o_fired <= 1'b0;
                r_o_track <= r_tracking;
                r_o_pan   <= r_pan;
                r_o_tilt  <= r_tilt;
                r_o_pmv   <= 1'b0;
                r_o_tmv   <= 1'b0;
            end
        end
    end

    assign o_drive_enable    = r_o_en;
    assign o_forward_speed   = $signed(r_o_fwd);
    assign o_lateral_speed   = $signed(r_o_lat);
    assign o_rotate_speed    = $signed(r_o_rot);
    assign o_toggle_fired    = r_o_fired;
    assign o_tracking_active = r_o_track;
    assign o_pan_angle       = $signed(r_o_pan);
    assign o_tilt_angle      = $signed(r_o_tilt);
    assign o_pan_moved       = r_o_pmv;
    assign o_tilt_moved      = r_o_tmv;

endmodule
`default_nettype wire

// ===== sim/tb_gamepad_drive_and_gimbal_control_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_gamepad_drive_and_gimbal_control_core: frame-level check of the core
// Feeds polled gamepad frames through the valid/ready input channel, predicts
// every result item from its own model of the drive, tracking toggle and
// gimbal logic, and compares each result field by field as it is taken.
// ============================================================================
module tb_gamepad_drive_and_gimbal_control_core;

    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no item moving
    localparam int SETTLE_CYCLES  = 8;     // result latency plus margin

    // One polled frame, in port order.
    typedef struct packed {
        logic [7:0] mode;
        logic [7:0] lh;
        logic [7:0] lv;
        logic [7:0] rh;
        logic [7:0] rv;
        logic       up;
        logic       down;
        logic       right;
        logic       left;
        logic       sel;
        logic [3:0] btns;
    } t_pad_frame;

    // One result item, in port order.
    typedef struct packed {
        logic                                en;
        logic signed [gdgc_pkg::SPEED_W-1:0] fwd;
        logic signed [gdgc_pkg::SPEED_W-1:0] lat;
        logic signed [gdgc_pkg::SPEED_W-1:0] rot;
        logic                                fired;
        logic                                trk;
        logic signed [gdgc_pkg::ANGLE_W-1:0] pan;
        logic signed [gdgc_pkg::ANGLE_W-1:0] tilt;
        logic                                pmov;
        logic                                tmov;
    } t_drive_result;

    // ------------------------------------------------------------------------
    // Drive/gimbal predictor and the queue of results it still owes.
    // ------------------------------------------------------------------------
    class t_gimbal_scoreboard;
        int gain, dead_zone, cooldown_len, debounce_max, servo_step, angle_lim;
        bit sel_prev, tracking;
        int cooldown;
        int agree [4];
        bit level [4];
        int pan, tilt, pan_sent, tilt_sent;
        t_drive_result expected_q [$];
        int errors, checked, stop_items, toggles;

        function new();
            gain = 12;
            dead_zone = 6;
            cooldown_len = 15;
            debounce_max = 3;
            servo_step = 12;
            angle_lim = 900;
            sel_prev = 0;
            tracking = 0;
            cooldown = 0;
            for (int i = 0; i < 4; i++) begin
                agree[i] = 0;
                level[i] = 0;
            end
            pan = 0;
            tilt = 0;
            pan_sent = 0;
            tilt_sent = 0;
            errors = 0;
            checked = 0;
            stop_items = 0;
            toggles = 0;
        endfunction

        function void set_reg(logic [gdgc_pkg::CFG_IDX_W-1:0] idx, int value);
            case (idx)
                gdgc_pkg::CFG_SPEED_GAIN:      gain = value & 'hFF;
                gdgc_pkg::CFG_DEAD_ZONE:       dead_zone = value & 'hFF;
                gdgc_pkg::CFG_TOGGLE_COOLDOWN: cooldown_len = value & 'hFF;
                gdgc_pkg::CFG_DEBOUNCE_LIMIT:  debounce_max = value & 'hF;
                gdgc_pkg::CFG_SERVO_STEP:      servo_step = value & 'h7F;
                gdgc_pkg::CFG_ANGLE_LIMIT:     angle_lim = value & 'h3FFF;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int centre(logic [7:0] raw, bit inverted);
            int v;
            v = inverted ? 128 - int'(raw) : int'(raw) - 128;
            if (v > -dead_zone && v < dead_zone) v = 0;
            return v;
        endfunction

        function int clamp_to_limit(int v);
            if (v > angle_lim) v = angle_lim;
            if (v < -angle_lim) v = -angle_lim;
            return v;
        endfunction

        function void note_frame(t_pad_frame f);
            t_drive_result r;
            int fwd, side, rot, i;
            r = '0;
            if (f.mode != 8'h73 || {f.lh, f.lv, f.rh, f.rv} == 32'h0
                    || {f.lh, f.lv, f.rh, f.rv} == 32'hFFFF_FFFF) begin
                stop_items++;
            end else begin
                fwd = centre(f.lv, 1);
                side = centre(f.lh, 0);
                rot = centre(f.rh, 0);
                if (f.up) fwd = 128;
                if (f.down) fwd = -127;
                if (f.right) side = 127;
                if (f.left) side = -128;
                r.en = 1'b1;
                r.fwd = 16'(gain * fwd);
                r.lat = 16'((gain * -side * 13) / 10);
                r.rot = 16'(4 * gain * -rot);

                if (cooldown > 0) cooldown--;
                if (sel_prev && !f.sel && cooldown == 0) begin
                    tracking = !tracking;
                    cooldown = cooldown_len;
                    r.fired = 1'b1;
                    toggles++;
                end
                sel_prev = f.sel;

                if (!tracking) begin
                    for (i = 0; i < 4; i++) begin
                        if (f.btns[i] == level[i]) begin
                            if (agree[i] < debounce_max) agree[i]++;
                        end else if (agree[i] > 0) begin
                            agree[i]--;
                        end else begin
                            level[i] = f.btns[i];
                        end
                        if (level[i]) begin
                            case (i)
                                0: pan += servo_step;
                                1: pan -= servo_step;
                                2: tilt += servo_step;
                                default: tilt -= servo_step;
                            endcase
                        end
                    end
                    pan = clamp_to_limit(pan);
                    tilt = clamp_to_limit(tilt);
                    if (pan != pan_sent) begin
                        r.pmov = 1'b1;
                        pan_sent = pan;
                    end
                    if (tilt != tilt_sent) begin
                        r.tmov = 1'b1;
                        tilt_sent = tilt;
                    end
                end
            end
            r.trk = tracking;
            r.pan = 15'(pan);
            r.tilt = 15'(tilt);
            expected_q.push_back(r);
        endfunction

        function void compare(string field, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(t_drive_result got);
            t_drive_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result item with no frame waiting for it", $time);
            end else begin
                want = expected_q.pop_front();
                checked++;
                compare("drive_enable", want.en, got.en);
                compare("forward_speed", want.fwd, got.fwd);
                compare("lateral_speed", want.lat, got.lat);
                compare("rotate_speed", want.rot, got.rot);
                compare("toggle_fired", want.fired, got.fired);
                compare("tracking_active", want.trk, got.trk);
                compare("pan_angle", want.pan, got.pan);
                compare("tilt_angle", want.tilt, got.tilt);
                compare("pan_moved", want.pmov, got.pmov);
                compare("tilt_moved", want.tmov, got.tmov);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [gdgc_pkg::CFG_IDX_W-1:0]      i_cfg_idx;
    logic [gdgc_pkg::CFG_DATA_W-1:0]     i_cfg_data;
    logic                                i_valid;
    logic                                o_ready;
    logic [7:0]                          i_pad_mode;
    logic [7:0]                          i_left_horizontal;
    logic [7:0]                          i_left_vertical;
    logic [7:0]                          i_right_horizontal;
    logic [7:0]                          i_right_vertical;
    logic                                i_pad_up;
    logic                                i_pad_down;
    logic                                i_pad_right;
    logic                                i_pad_left;
    logic                                i_select_held;
    logic [3:0]                          i_servo_buttons;
    logic                                o_valid;
    logic                                i_ready;
    logic                                o_drive_enable;
    logic signed [gdgc_pkg::SPEED_W-1:0] o_forward_speed;
    logic signed [gdgc_pkg::SPEED_W-1:0] o_lateral_speed;
    logic signed [gdgc_pkg::SPEED_W-1:0] o_rotate_speed;
    logic                                o_toggle_fired;
    logic                                o_tracking_active;
    logic signed [gdgc_pkg::ANGLE_W-1:0] o_pan_angle;
    logic signed [gdgc_pkg::ANGLE_W-1:0] o_tilt_angle;
    logic                                o_pan_moved;
    logic                                o_tilt_moved;

    t_gimbal_scoreboard sb = new();

    int send_idle_pct = 22;   // chance per item that the sender inserts a gap
    int recv_idle_pct = 46;   // chance per cycle that the receiver stalls
    int quiet_cycles  = 0;

    // Run state for the random frames: select and servo buttons are held for
    // stretches so that toggles and debounced presses actually happen.
    bit         sel_level = 0;
    int         sel_run   = 0;
    logic [3:0] btn_level = '0;
    int         btn_run   = 0;

    gamepad_drive_and_gimbal_control_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_pad_mode         (i_pad_mode),
        .i_left_horizontal  (i_left_horizontal),
        .i_left_vertical    (i_left_vertical),
        .i_right_horizontal (i_right_horizontal),
        .i_right_vertical   (i_right_vertical),
        .i_pad_up           (i_pad_up),
        .i_pad_down         (i_pad_down),
        .i_pad_right        (i_pad_right),
        .i_pad_left         (i_pad_left),
        .i_select_held      (i_select_held),
        .i_servo_buttons    (i_servo_buttons),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_drive_enable     (o_drive_enable),
        .o_forward_speed    (o_forward_speed),
        .o_lateral_speed    (o_lateral_speed),
        .o_rotate_speed     (o_rotate_speed),
        .o_toggle_fired     (o_toggle_fired),
        .o_tracking_active  (o_tracking_active),
        .o_pan_angle        (o_pan_angle),
        .o_tilt_angle       (o_tilt_angle),
        .o_pan_moved        (o_pan_moved),
        .o_tilt_moved       (o_tilt_moved)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Receiver: stall at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: check result items, note accepted frames, watch for a hang.
    // Check before noting so a frame taken in the same cycle queues behind.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_result({o_drive_enable, o_forward_speed, o_lateral_speed,
                                 o_rotate_speed, o_toggle_fired, o_tracking_active,
                                 o_pan_angle, o_tilt_angle, o_pan_moved, o_tilt_moved});
            if (i_valid && o_ready)
                sb.note_frame({i_pad_mode, i_left_horizontal, i_left_vertical,
                               i_right_horizontal, i_right_vertical, i_pad_up,
                               i_pad_down, i_pad_right, i_pad_left, i_select_held,
                               i_servo_buttons});
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no item moved for %0d cycles",
                         $time, WATCHDOG_LIMIT);
                $display("tb_gamepad_drive_and_gimbal_control_core: done, errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic t_pad_frame make_frame(logic [7:0] mode, logic [7:0] lh,
                                              logic [7:0] lv, logic [7:0] rh,
                                              logic [7:0] rv, logic [3:0] dpad,
                                              logic sel, logic [3:0] btns);
        return {mode, lh, lv, rh, rv, dpad, sel, btns};
    endfunction

    // Bias the sticks toward the centre band and the rails, where the dead
    // zone and the speed wrap live.
    function automatic logic [7:0] random_axis();
        int pick;
        logic [7:0] v;
        pick = $urandom_range(99);
        if (pick < 25) begin
            v = 8'(128 + int'($urandom_range(20)) - 10);
        end else if (pick < 40) begin
            case ($urandom_range(5))
                0: v = 8'h00;
                1: v = 8'hFF;
                2: v = 8'h01;
                3: v = 8'hFE;
                4: v = 8'h7F;
                default: v = 8'h81;
            endcase
        end else begin
            v = 8'($urandom);
        end
        return v;
    endfunction

    function automatic t_pad_frame random_frame();
        t_pad_frame f;
        int kind;
        kind = $urandom_range(99);
        f.mode = 8'h73;
        f.lh = random_axis();
        f.lv = random_axis();
        f.rh = random_axis();
        f.rv = random_axis();
        // Mostly analog-mode frames; the rest are wrong mode or dead sticks.
        if (kind < 6)
            f.mode = 8'($urandom);
        else if (kind < 9)
            {f.lh, f.lv, f.rh, f.rv} = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        f.up = ($urandom_range(99) < 15);
        f.down = ($urandom_range(99) < 15);
        f.right = ($urandom_range(99) < 15);
        f.left = ($urandom_range(99) < 15);
        if (sel_run == 0) begin
            sel_level = !sel_level;
            sel_run = $urandom_range(1, 6);
        end
        sel_run--;
        f.sel = sel_level;
        if (btn_run == 0) begin
            btn_level = 4'($urandom);
            btn_run = $urandom_range(1, 15);
        end
        btn_run--;
        f.btns = btn_level;
        // Flip a button now and then to exercise the debounce counters.
        if ($urandom_range(99) < 15) f.btns[$urandom_range(3)] ^= 1'b1;
        return f;
    endfunction

    // Present one frame and hold it until the core takes it.
    task automatic push_frame(input t_pad_frame f);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_pad_mode, i_left_horizontal, i_left_vertical, i_right_horizontal,
         i_right_vertical, i_pad_up, i_pad_down, i_pad_right, i_pad_left,
         i_select_held, i_servo_buttons} <= f;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Drop valid and wait until every owed result is back, then let the
    // pipeline settle. The first edge lets the monitor note the last frame.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [gdgc_pkg::CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[gdgc_pkg::CFG_DATA_W-1:0];
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic program_regs(input int gain, input int dz, input int cd,
                                input int dbl, input int st, input int lim);
        write_reg(gdgc_pkg::CFG_SPEED_GAIN, gain);
        write_reg(gdgc_pkg::CFG_DEAD_ZONE, dz);
        write_reg(gdgc_pkg::CFG_TOGGLE_COOLDOWN, cd);
        write_reg(gdgc_pkg::CFG_DEBOUNCE_LIMIT, dbl);
        write_reg(gdgc_pkg::CFG_SERVO_STEP, st);
        write_reg(gdgc_pkg::CFG_ANGLE_LIMIT, lim);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int seg, n;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        {i_pad_mode, i_left_horizontal, i_left_vertical, i_right_horizontal,
         i_right_vertical, i_pad_up, i_pad_down, i_pad_right, i_pad_left,
         i_select_held, i_servo_buttons} = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames on the reset register values.
        // Stop cases: wrong mode, all sticks at 0x00, all sticks at 0xFF.
        push_frame(make_frame(8'h72, 8'h80, 8'h80, 8'h80, 8'h80, 4'b0000, 0, 4'h0));
        push_frame(make_frame(8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 4'b0000, 0, 4'h0));
        push_frame(make_frame(8'h73, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'b0000, 0, 4'h0));
        // Centred sticks, then the stick rails.
        push_frame(make_frame(8'h73, 8'h80, 8'h80, 8'h80, 8'h80, 4'b0000, 0, 4'h0));
        push_frame(make_frame(8'h73, 8'h00, 8'h00, 8'hFF, 8'h12, 4'b0000, 0, 4'h0));
        push_frame(make_frame(8'h73, 8'hFF, 8'hFF, 8'h00, 8'h00, 4'b0000, 0, 4'h0));
        // Dead zone edges: magnitude 5 drops, magnitude 6 passes with both signs.
        push_frame(make_frame(8'h73, 8'h85, 8'h7B, 8'h86, 8'h80, 4'b0000, 0, 4'h0));
        push_frame(make_frame(8'h73, 8'h7A, 8'h86, 8'h7A, 8'h80, 4'b0000, 0, 4'h0));
        // D-pad {up, down, right, left}: single presses and both conflicts.
        push_frame(make_frame(8'h73, 8'h30, 8'h90, 8'h80, 8'h80, 4'b1000, 0, 4'h0));
        push_frame(make_frame(8'h73, 8'h30, 8'h90, 8'h80, 8'h80, 4'b1100, 0, 4'h0));
        push_frame(make_frame(8'h73, 8'h30, 8'h90, 8'h80, 8'h80, 4'b0010, 0, 4'h0));
        push_frame(make_frame(8'h73, 8'h30, 8'h90, 8'h80, 8'h80, 4'b0011, 0, 4'h0));
        // Servo buttons: hold pan plus, then swap to both tilt buttons.
        push_frame(make_frame(8'h73, 8'h80, 8'h80, 8'h80, 8'h80, 4'b0000, 0, 4'h1));
        push_frame(make_frame(8'h73, 8'h80, 8'h80, 8'h80, 8'h80, 4'b0000, 0, 4'h1));
        push_frame(make_frame(8'h73, 8'h80, 8'h80, 8'h80, 8'h80, 4'b0000, 0, 4'h1));
        push_frame(make_frame(8'h73, 8'h80, 8'h80, 8'h80, 8'h80, 4'b0000, 0, 4'hC));
        push_frame(make_frame(8'h73, 8'h80, 8'h80, 8'h80, 8'h80, 4'b0000, 0, 4'hC));
        // Select press and release toggles tracking on; servos then freeze.
        push_frame(make_frame(8'h73, 8'h80, 8'h80, 8'h80, 8'h80, 4'b0000, 1, 4'h0));
        push_frame(make_frame(8'h73, 8'h80, 8'h80, 8'h80, 8'h80, 4'b0000, 0, 4'h0));
        push_frame(make_frame(8'h73, 8'h80, 8'h80, 8'h80, 8'h80, 4'b0000, 0, 4'hF));
        // Stop frame with select held must leave select history alone.
        push_frame(make_frame(8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 4'b0000, 1, 4'hF));
        // Second release falls inside the cooldown and is ignored.
        push_frame(make_frame(8'h73, 8'h80, 8'h80, 8'h80, 8'h80, 4'b0000, 1, 4'h0));
        push_frame(make_frame(8'h73, 8'h80, 8'h80, 8'h80, 8'h80, 4'b0000, 0, 4'h0));
        push_frame(make_frame(8'h73, 8'hFF, 8'h00, 8'h00, 8'h00, 4'b0000, 0, 4'h0));

        // Random segments, each on its own register set. Idle mixes: sender
        // light / receiver heavy, then reversed, then no idling at all.
        for (seg = 0; seg < 6; seg++) begin
            if (seg < 2) begin
                send_idle_pct = 22;
                recv_idle_pct = 46;
            end else if (seg < 4) begin
                send_idle_pct = 46;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain();
            case (seg)
                0: program_regs(255, 0, 0, 15, 127, 16000);
                1: program_regs(0, 128, 255, 0, 1, 0);   // counters above new limit
                2: program_regs(37, 255, 3, 1, 100, 500); // dead zone swallows sticks
                3: program_regs(12, 6, 15, 3, 12, 900);
                4: program_regs(200, 20, 1, 7, 0, 16000);
                default: program_regs(90, 1, 8, 2, 60, 300);
            endcase
            for (n = 0; n < 155; n++) begin
                // Hold the sender mid-segment until the core runs dry.
                if (n == 80) drain();
                push_frame(random_frame());
            end
        end

        drain();
        $display("checked %0d result items: %0d stop items, %0d tracking toggles",
                 sb.checked, sb.stop_items, sb.toggles);
        $display("covered reset registers plus six programmed sets under three idle mixes");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_gamepad_drive_and_gimbal_control_core: done, clean");
        end else begin
            $display("tb_gamepad_drive_and_gimbal_control_core: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/gdgc_pkg.sv
design/gdgc_ctrl.sv
design/gdgc_dp.sv
design/gamepad_drive_and_gimbal_control_core.sv
sim/tb_gamepad_drive_and_gimbal_control_core.sv
